// ===== sv/rsn_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsn_pkg
// Shared types, constants and helpers of the record sorter.
// ----------------------------------------------------------------------------
package rsn_pkg;

	localparam int RSN_MAX_RECORDS = 64;
	localparam int RSN_NAME_BYTES  = 32;
	localparam int NAME_WORDS      = 4;
	localparam int KEY_BYTES       = NAME_WORDS * 8;

	typedef logic [NAME_WORDS-1:0][63:0] name_t;

	typedef struct packed {
		name_t              name;
		logic signed [31:0] quantity;
		logic [31:0]        price;
	} rec_t;

	// byte mask of one name word: bytes at or beyond name_bytes are cleared
	function automatic logic [63:0] name_mask(input int word, input int name_bytes);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (8 * word + b < name_bytes) begin
				m[8*b +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage
`default_nettype wire

// ===== sv/rsn_load_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsn_load_if
// Record load channel: one record per request, last_record closes the set.
// ----------------------------------------------------------------------------
interface rsn_load_if;
	logic               valid;
	logic               ready;
	logic [63:0]        name_word0;
	logic [63:0]        name_word1;
	logic [63:0]        name_word2;
	logic [63:0]        name_word3;
	logic signed [31:0] quantity;
	logic [31:0]        price_bits;
	logic               last_record;

	modport source (
		output valid, name_word0, name_word1, name_word2, name_word3,
		output quantity, price_bits, last_record,
		input  ready
	);
	modport sink (
		input  valid, name_word0, name_word1, name_word2, name_word3,
		input  quantity, price_bits, last_record,
		output ready
	);
endinterface
`default_nettype wire

// ===== sv/rsn_result_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsn_result_if
// Sorted record channel: one record per request, out_last ends the run.
// ----------------------------------------------------------------------------
interface rsn_result_if;
	logic               valid;
	logic               ready;
	logic [63:0]        out_name_word0;
	logic [63:0]        out_name_word1;
	logic [63:0]        out_name_word2;
	logic [63:0]        out_name_word3;
	logic signed [31:0] out_quantity;
	logic [31:0]        out_price_bits;
	logic               out_last;

	modport source (
		output valid, out_name_word0, out_name_word1, out_name_word2, out_name_word3,
		output out_quantity, out_price_bits, out_last,
		input  ready
	);
	modport sink (
		input  valid, out_name_word0, out_name_word1, out_name_word2, out_name_word3,
		input  out_quantity, out_price_bits, out_last,
		output ready
	);
endinterface
`default_nettype wire

// ===== sv/rsn_rec_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsn_rec_mem
// Record memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rsn_rec_mem
	import rsn_pkg::*;
#(
	parameter int DEPTH = RSN_MAX_RECORDS,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  rec_t          wdata,
	input  logic [AW-1:0] raddr,
	output rec_t          rdata
);

	rec_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== sv/rsn_name_cmp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsn_name_cmp
// Name compare: a strictly greater than b, byte order, stops at terminator.
// ----------------------------------------------------------------------------
module rsn_name_cmp
	import rsn_pkg::*;
(
	input  name_t a,
	input  name_t b,
	output logic  greater
);

	logic [KEY_BYTES-1:0] stop;
	logic [KEY_BYTES-1:0] gt;
	logic [KEY_BYTES-1:0] first;

	// per byte: a difference or a shared terminator ends the compare
	always_comb begin
		for (int k = 0; k < KEY_BYTES; k++) begin
			stop[k] = (a[k/8][8*(k%8) +: 8] != b[k/8][8*(k%8) +: 8]) ||
			          (a[k/8][8*(k%8) +: 8] == 8'd0);
			gt[k]   = a[k/8][8*(k%8) +: 8] > b[k/8][8*(k%8) +: 8];
		end
	end

	// lowest stopping byte decides
	assign first   = stop & (~stop + {{(KEY_BYTES-1){1'b0}}, 1'b1});
	assign greater = |(first & gt);

endmodule
`default_nettype wire

// ===== sv/record_sort_by_name_key.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// record_sort_by_name_key
// Loads a set of records, sorts them by name key and streams them out.
// ----------------------------------------------------------------------------
// Records are loaded one per request on load; the request with last_record
// set closes the set. Up to MAX_RECORDS records are kept, later ones are
// dropped (a dropped last_record still starts the sort). The set is then
// sorted in place in a single-port-read, single-port-write record memory
// by exchange sort: record i sits in a holding register while records
// i+1..n-1 are read one per cycle, compared byte-wise against it
// (unsigned, strcmp-like) and swapped on strictly greater, with one
// memory read per compare. Each record is then output through a memory
// read and then the result register, and out_last marks the final one.
// The load port opens again as soon as the final record sits in the
// result register, so the next set can load while it waits to be taken.
// ----------------------------------------------------------------------------
module record_sort_by_name_key
	import rsn_pkg::*;
#(
	parameter int MAX_RECORDS = RSN_MAX_RECORDS,
	parameter int NAME_BYTES  = RSN_NAME_BYTES
) (
	input  logic clk,
	input  logic arst_n,
	rsn_load_if.sink     load,
	rsn_result_if.source result
);

	localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int CW = $clog2(MAX_RECORDS + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_GETI = 3'd1;
	localparam logic [2:0] S_CMP  = 3'd2;
	localparam logic [2:0] S_WB   = 3'd3;
	localparam logic [2:0] S_ORD  = 3'd4;
	localparam logic [2:0] S_OCAP = 3'd5;

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;     // records held, also sort length
	logic [AW-1:0] i_q;
	logic [AW-1:0] j_q;
	logic [AW-1:0] o_q;
	rec_t          held_q;      // record at position i during a pass
	rec_t          out_rec_q;
	logic          out_valid_q;
	logic          out_last_q;

	logic          we;
	logic [AW-1:0] waddr;
	rec_t          wdata;
	logic [AW-1:0] raddr;
	rec_t          rdata;
	logic          greater;
	rec_t          load_rec;
	logic          load_fire;
	logic          has_room;
	logic [CW-1:0] n_minus1;
	logic          j_at_end;
	logic          i_at_end;
	logic          o_at_end;
	logic          out_free;

	rsn_rec_mem #(
		.DEPTH (MAX_RECORDS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	rsn_name_cmp u_cmp (
		.a       (held_q.name),
		.b       (rdata.name),
		.greater (greater)
	);

	// incoming record, name bytes past the key length cleared
	assign load_rec.name[0]  = load.name_word0 & name_mask(0, NAME_BYTES);
	assign load_rec.name[1]  = load.name_word1 & name_mask(1, NAME_BYTES);
	assign load_rec.name[2]  = load.name_word2 & name_mask(2, NAME_BYTES);
	assign load_rec.name[3]  = load.name_word3 & name_mask(3, NAME_BYTES);
	assign load_rec.quantity = load.quantity;
	assign load_rec.price    = load.price_bits;

	assign load.ready = (state_q == S_IDLE);
	assign load_fire  = load.valid && load.ready;
	assign has_room   = count_q < CW'(MAX_RECORDS);

	assign n_minus1 = count_q - {{(CW-1){1'b0}}, 1'b1};
	assign j_at_end = CW'(j_q) == n_minus1;
	assign i_at_end = (CW'(i_q) + {{(CW-1){1'b0}}, 1'b1}) == n_minus1;
	assign o_at_end = CW'(o_q) == n_minus1;
	assign out_free = !out_valid_q || result.ready;

	// memory port steering
	always_comb begin
		we    = 1'b0;
		waddr = j_q;
		wdata = held_q;
		raddr = j_q;
		unique case (state_q)
			S_IDLE: begin
				we    = load_fire && has_room;
				waddr = count_q[AW-1:0];
				wdata = load_rec;
				raddr = '0;
			end
			S_GETI: begin
				raddr = j_q;
			end
			S_CMP: begin
				// swap: old record i goes to slot j, record j is held
				we    = greater;
				waddr = j_q;
				wdata = held_q;
				raddr = j_q + {{(AW-1){1'b0}}, 1'b1};
			end
			S_WB: begin
				we    = 1'b1;
				waddr = i_q;
				wdata = held_q;
				raddr = i_q + {{(AW-1){1'b0}}, 1'b1};
			end
			S_ORD: begin
				raddr = o_q;
			end
			S_OCAP: begin
				raddr = o_q;
			end
			default: begin
				raddr = j_q;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
			o_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (load_fire) begin
						if (has_room) begin
							count_q <= count_q + {{(CW-1){1'b0}}, 1'b1};
						end
						if (load.last_record) begin
							i_q <= '0;
							j_q <= {{(AW-1){1'b0}}, 1'b1};
							o_q <= '0;
							// a single record needs no sort
							if (count_q == '0 || (count_q == {{(CW-1){1'b0}}, 1'b1} && !has_room)) begin
								state_q <= S_ORD;
							end else begin
								state_q <= S_GETI;
							end
						end
					end
				end
				S_GETI: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (j_at_end) begin
						state_q <= S_WB;
					end else begin
						j_q <= j_q + {{(AW-1){1'b0}}, 1'b1};
					end
				end
				S_WB: begin
					if (i_at_end) begin
						o_q     <= '0;
						state_q <= S_ORD;
					end else begin
						i_q     <= i_q + {{(AW-1){1'b0}}, 1'b1};
						j_q     <= i_q + AW'(2);
						state_q <= S_GETI;
					end
				end
				S_ORD: begin
					if (out_free) begin
						state_q <= S_OCAP;
					end
				end
				S_OCAP: begin
					if (o_at_end) begin
						count_q <= '0;
						state_q <= S_IDLE;
					end else begin
						o_q     <= o_q + {{(AW-1){1'b0}}, 1'b1};
						state_q <= S_ORD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// holding register for record i
	always_ff @(posedge clk) begin
		if (state_q == S_GETI || (state_q == S_CMP && greater)) begin
			held_q <= rdata;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OCAP) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OCAP) begin
			out_rec_q  <= rdata;
			out_last_q <= o_at_end;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.out_name_word0 = out_rec_q.name[0];
	assign result.out_name_word1 = out_rec_q.name[1];
	assign result.out_name_word2 = out_rec_q.name[2];
	assign result.out_name_word3 = out_rec_q.name[3];
	assign result.out_quantity   = out_rec_q.quantity;
	assign result.out_price_bits = out_rec_q.price;
	assign result.out_last       = out_last_q;

endmodule
`default_nettype wire
